### rtl/mmts_pkg.sv
// Package for the min/max tracking stack.
// Holds operation and status codes, word constants and the controller/datapath
// command and status structs. No dependencies.
package mmts_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IN_W      = 40;   // func + value, padded to bytes
  localparam int unsigned OUT_W     = 112;  // data, min, max, count, status, padded
  localparam int unsigned CAP_RESET = 256;

  localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OVF  = 2'd1,
    STAT_UDF  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic push;        // store value, bump count
    logic ovf;         // flag overflow
    logic udf;         // flag underflow
    logic rd_top;      // read top entry
    logic pop;         // drop top entry
    logic rd_take;     // latch read word as result data
    logic scan_start;  // clear min/max, read entry 0
    logic scan_step;   // fold read word, read next entry
    logic out_load;    // move result into output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       empty;
    logic       full;
    logic       hit;        // read word equals min or max
    logic       scan_last;  // word of last entry is on the read port
    logic       out_free;
  } sts_t;

endpackage

### rtl/mmts_datapath.sv
// Datapath of the min/max tracking stack: entry memory, count, running
// min/max, capacity register and output register. Uses mmts_pkg.
module mmts_datapath #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mmts_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic [mmts_pkg::IN_W-1:0]   s_tdata_i,
  input  mmts_pkg::cmd_t              cmd_i,
  output mmts_pkg::sts_t              sts_o,
  input  logic                        m_tready_i,
  output logic                        m_tvalid_o,
  output logic [mmts_pkg::OUT_W-1:0]  m_tdata_o
);

  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_LIM = (DEPTH < 511) ? DEPTH : 511;
  localparam int unsigned PAD_W   = mmts_pkg::OUT_W - 3 * mmts_pkg::WORD_W
                                    - mmts_pkg::CNT_W - 2;

  logic [mmts_pkg::WORD_W-1:0]        mem [DEPTH];

  logic [mmts_pkg::CNT_W-1:0]         cap_q;
  logic [mmts_pkg::CNT_W-1:0]         eff_cap;
  logic [mmts_pkg::CNT_W-1:0]         count_q, count_d;
  logic [mmts_pkg::CNT_W-1:0]         scan_idx_q, scan_idx_d;
  logic signed [mmts_pkg::WORD_W-1:0] min_q, min_d, max_q, max_d;
  logic signed [mmts_pkg::WORD_W-1:0] data_q, data_d;
  logic [1:0]                         status_q, status_d;
  logic signed [mmts_pkg::WORD_W-1:0] rd_data_q;
  logic signed [mmts_pkg::WORD_W-1:0] in_value;
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic                               m_tvalid_q;
  logic [mmts_pkg::OUT_W-1:0]         m_tdata_q;

  assign in_value = s_tdata_i[mmts_pkg::WORD_W+1:2];
  assign eff_cap  = (cap_q > mmts_pkg::CNT_W'(CAP_LIM)) ? mmts_pkg::CNT_W'(CAP_LIM) : cap_q;

  assign sts_o.func      = s_tdata_i[1:0];
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q >= eff_cap);
  assign sts_o.hit       = (rd_data_q == min_q) || (rd_data_q == max_q);
  assign sts_o.scan_last = (scan_idx_q == count_q);
  assign sts_o.out_free  = !m_tvalid_q || m_tready_i;

  always_comb begin
    count_d    = count_q;
    min_d      = min_q;
    max_d      = max_q;
    data_d     = data_q;
    status_d   = status_q;
    scan_idx_d = scan_idx_q;
    rd_en      = 1'b0;
    rd_addr    = AW'(count_q - mmts_pkg::CNT_W'(1));
    if (cmd_i.push) begin
      count_d  = count_q + mmts_pkg::CNT_W'(1);
      data_d   = in_value;
      status_d = mmts_pkg::STAT_OK;
      if (in_value < min_q) min_d = in_value;
      if (in_value > max_q) max_d = in_value;
    end
    if (cmd_i.ovf) begin
      data_d   = '0;
      status_d = mmts_pkg::STAT_OVF;
    end
    if (cmd_i.udf) begin
      data_d   = '0;
      status_d = mmts_pkg::STAT_UDF;
    end
    if (cmd_i.rd_top) begin
      rd_en    = 1'b1;
      status_d = mmts_pkg::STAT_OK;
    end
    if (cmd_i.pop) begin
      count_d = count_q - mmts_pkg::CNT_W'(1);
    end
    if (cmd_i.rd_take) begin
      data_d = rd_data_q;
    end
    if (cmd_i.scan_start) begin
      min_d      = mmts_pkg::INT_MAX;
      max_d      = mmts_pkg::INT_MIN;
      rd_en      = 1'b1;
      rd_addr    = '0;
      scan_idx_d = mmts_pkg::CNT_W'(1);
    end
    if (cmd_i.scan_step) begin
      if (rd_data_q < min_q) min_d = rd_data_q;
      if (rd_data_q > max_q) max_d = rd_data_q;
      if (!sts_o.scan_last) begin
        rd_en      = 1'b1;
        rd_addr    = AW'(scan_idx_q);
        scan_idx_d = scan_idx_q + mmts_pkg::CNT_W'(1);
      end
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[AW'(count_q)] <= in_value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= mmts_pkg::CNT_W'(mmts_pkg::CAP_RESET);
      count_q    <= '0;
      min_q      <= mmts_pkg::INT_MAX;
      max_q      <= mmts_pkg::INT_MIN;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
      if (cmd_i.out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    status_q   <= status_d;
    scan_idx_q <= scan_idx_d;
    if (cmd_i.out_load) begin
      m_tdata_q <= {PAD_W'(0), status_q, count_q, max_q, min_q, data_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

endmodule

### rtl/mmts_ctrl.sv
// Controller of the min/max tracking stack: sequences push, pop, query and
// the min/max rescan. Uses mmts_pkg.
module mmts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  mmts_pkg::sts_t sts_i,
  output mmts_pkg::cmd_t cmd_o
);

  mmts_pkg::state_e state_q, state_d;
  logic             pop_q;
  logic             accept;

  assign s_tready_o = (state_q == mmts_pkg::ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (sts_i.func)
            mmts_pkg::FUNC_PUSH: state_d = mmts_pkg::ST_FIN;
            default:             state_d = sts_i.empty ? mmts_pkg::ST_FIN : mmts_pkg::ST_RD;
          endcase
        end
      end
      mmts_pkg::ST_RD: begin
        state_d = (pop_q && sts_i.hit && !sts_i.empty) ? mmts_pkg::ST_SCAN : mmts_pkg::ST_FIN;
      end
      mmts_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = mmts_pkg::ST_FIN;
      end
      mmts_pkg::ST_FIN: begin
        if (sts_i.out_free) state_d = mmts_pkg::ST_IDLE;
      end
      default: state_d = mmts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      mmts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (sts_i.func)
            mmts_pkg::FUNC_PUSH: begin
              cmd_o.push = !sts_i.full;
              cmd_o.ovf  = sts_i.full;
            end
            mmts_pkg::FUNC_POP: begin
              cmd_o.udf    = sts_i.empty;
              cmd_o.rd_top = !sts_i.empty;
              cmd_o.pop    = !sts_i.empty;
            end
            default: begin
              cmd_o.udf    = sts_i.empty;
              cmd_o.rd_top = !sts_i.empty;
            end
          endcase
        end
      end
      mmts_pkg::ST_RD: begin
        cmd_o.rd_take    = 1'b1;
        cmd_o.scan_start = pop_q && sts_i.hit;
      end
      mmts_pkg::ST_SCAN: cmd_o.scan_step = 1'b1;
      mmts_pkg::ST_FIN:  cmd_o.out_load  = sts_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmts_pkg::ST_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) pop_q <= (sts_i.func == mmts_pkg::FUNC_POP);
    end
  end

endmodule

### rtl/min_max_tracking_stack.sv
// Min/max tracking stack: LIFO of signed 32-bit words with running min/max.
// Push, overflow and underflow: IDLE, then FIN. Pop or query: IDLE, RD, FIN.
// A pop that removes the min or max rescans the remaining N entries through
// the single memory read port in SCAN. One request is in work at a time.
// Reset (async, active low) empties the stack and sets capacity to 256.
module min_max_tracking_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i,    // capacity
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // func[1:0], value[33:2], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata    // data[31:0], stack_min[63:32],
                                       // stack_max[95:64], count[104:96],
                                       // status[106:105], zero pad
);

  mmts_pkg::cmd_t cmd;
  mmts_pkg::sts_t sts;

  mmts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmts_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

### rtl/mmts_checker.sv
// Port-level checks for the min/max tracking stack, bound to the top level.
// Depends on min_max_tracking_stack and mmts_pkg.
module mmts_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  logic [31:0] r_data, r_min, r_max;
  logic [8:0]  r_count;
  logic [1:0]  r_status;

  assign r_data   = m_axis_tdata[31:0];
  assign r_min    = m_axis_tdata[63:32];
  assign r_max    = m_axis_tdata[95:64];
  assign r_count  = m_axis_tdata[104:96];
  assign r_status = m_axis_tdata[106:105];

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r_status != mmts_pkg::STAT_OK) |-> (r_data == '0))
    else $error("failed request carries nonzero data");

  a_udf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r_status == mmts_pkg::STAT_UDF) |->
      (r_count == '0) && (r_min == mmts_pkg::INT_MAX) && (r_max == mmts_pkg::INT_MIN))
    else $error("underflow without empty-stack report");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r_count != '0) |-> ($signed(r_min) <= $signed(r_max)))
    else $error("min above max on a nonempty stack");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind min_max_tracking_stack mmts_checker u_mmts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
